/* rtl/core/aidq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aidq_pkg
// Shared types and constants of the alarm input debouncer with event queue:
// request payloads, configuration register indexes, controller commands.
// ----------------------------------------------------------------------------
package aidq_pkg;

  // field widths of the request and result payloads
  localparam int PIN_W  = 14;
  localparam int GAS_W  = 7;
  localparam int CODE_W = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_THRESHOLD = 2'd0,
    CFG_COUNT_CEILING   = 2'd1,
    CFG_KEY_THRESHOLD   = 2'd2,
    CFG_DRAIN_PERIOD    = 2'd3
  } cfg_idx_e;

  // register reset values
  localparam logic [7:0]  ALARM_THRESHOLD_RST = 8'd100;
  localparam logic [7:0]  COUNT_CEILING_RST   = 8'd200;
  localparam logic [7:0]  KEY_THRESHOLD_RST   = 8'd5;
  localparam logic [15:0] DRAIN_PERIOD_RST    = 16'd1000;

  // event code offset of a cleared alarm
  localparam logic [CODE_W-1:0] CLEAR_OFFSET = 7'd100;

  typedef logic [CODE_W-1:0] code_t;

  // channel index as carried between controller and datapath (up to 14 channels)
  typedef logic [3:0] ch_idx_t;

  typedef struct packed {
    logic [PIN_W-1:0] alarm_pins;
    logic             key_pin;
  } in_t;

  typedef struct packed {
    logic [GAS_W-1:0]  normal_lamps;
    logic [GAS_W-1:0]  over_lamps;
    logic [GAS_W-1:0]  under_lamps;
    logic              beep_on;
    logic              muted;
    logic [PIN_W-1:0]  qualified_status;
    logic              message_valid;
    logic [CODE_W-1:0] message_code;
    logic              queue_overflow;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic    tick;      // run drain, key, debounce and lamps on the accepted request
    logic    enq;       // check one channel for a status change and queue it
    ch_idx_t ch;        // channel under check
    logic    load_out;  // capture the result into the output register
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/core/alarm_input_debouncer_event_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_input_debouncer_event_queue
// Debounces alarm pins and a mute key per tick, drives gas lamps and buzzer,
// and queues status-change event codes that drain one per drain period.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | into      | in_valid_i / in_stall_o   | in_data_i  (in_t)
//   out     | out of    | out_valid_o / out_stall_i | out_data_o (out_t)
//   cfg     | into      | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// A request runs the tick update, then the event queue scan one channel at a
// time (one queue write port), and then the load of the result register.
// A held result stalls only the load; the next request is taken once loaded.
// Reset is asynchronous, active low, and leaves the queue empty.
// ----------------------------------------------------------------------------
module alarm_input_debouncer_event_queue #(
  parameter int CHANNELS    = 14,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [aidq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [aidq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire aidq_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output aidq_pkg::out_t                       out_data_o
);

  aidq_pkg::cmd_t cmd;

  // sequencer
  aidq_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath
  aidq_dp #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* rtl/core/aidq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aidq_ctrl
// Sequencer: takes a request, steps the channel scan that queues status
// changes, then loads the result register and hands back the input side.
// ----------------------------------------------------------------------------
module aidq_ctrl #(
  parameter int CHANNELS = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output aidq_pkg::cmd_t     cmd_o
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_LOAD
  } state_e;

  state_e         state_q;
  logic [CHW-1:0] ch_q;
  logic           out_valid_q;
  logic           out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // commands decoded from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.tick     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.enq      = (state_q == ST_ENQ);
    cmd_o.ch       = aidq_pkg::ch_idx_t'(ch_q);
    cmd_o.load_out = (state_q == ST_LOAD) && out_free;
  end

  // state, scan counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ch_q    <= '0;
            state_q <= ST_ENQ;
          end
        end
        ST_ENQ: begin
          if (ch_q == CHW'(CHANNELS - 1)) begin
            state_q <= ST_LOAD;
          end else begin
            ch_q <= ch_q + CHW'(1);
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // scan always starts at channel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |=> (cmd_o.enq && ch_q == '0))
    else $error("aidq_ctrl: scan did not start at channel zero");

  // a request reaches the result stage after exactly one pass over the channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |-> ##(CHANNELS + 1) (state_q == ST_LOAD))
    else $error("aidq_ctrl: channel scan length wrong");

  // loading the result always raises valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("aidq_ctrl: result loaded but not presented");
`endif

endmodule
`default_nettype wire

/* rtl/core/aidq_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aidq_dp
// Datapath: configuration registers, per-channel run counters and status,
// mute key debounce, lamp latches, drain counter, event queue memory and
// the result register.
// ----------------------------------------------------------------------------
module aidq_dp #(
  parameter int CHANNELS    = 14,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [aidq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [aidq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire aidq_pkg::in_t                       in_data_i,
  input  wire aidq_pkg::cmd_t                      cmd_i,
  output aidq_pkg::out_t                           out_data_o
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NG  = CHANNELS / 2;
  localparam int LW  = 2 * NG;
  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [7:0]  athr_q, ceil_q, kthr_q;
  logic [15:0] period_q;

  // channel state
  logic [7:0]          hi_cnt_q [CHANNELS];
  logic [7:0]          lo_cnt_q [CHANNELS];
  logic [7:0]          hi_cnt_d [CHANNELS];
  logic [7:0]          lo_cnt_d [CHANNELS];
  logic [CHANNELS-1:0] status_q, status_d, reported_q;

  // key, lamps, drain
  logic [7:0]    key_cnt_q, key_cnt_d;
  logic          key_lock_q, key_lock_d;
  logic          mute_q, mute_d;
  logic [LW-1:0] latch_q, latch_d;
  logic [NG-1:0] normal_q, normal_d;
  logic          any_alarm_q, any_alarm_d;
  logic [15:0]   dc_q, dc_inc;
  logic          drain_fire, pop;

  // event queue
  aidq_pkg::code_t mem [QUEUE_DEPTH];
  aidq_pkg::code_t rd_q, code_w;
  logic [AW-1:0]   head_q, tail_q;
  logic [FW-1:0]   fill_q;
  logic            msg_valid_q, ovf_q;
  logic            chg, full;
  logic [CHW-1:0]  ch;

  aidq_pkg::out_t  out_q, out_d;

  function automatic logic [7:0] run_adv(input logic [7:0] cnt, input logic [7:0] ceil);
    logic [7:0] c;
    c = (cnt > ceil) ? ceil : cnt;
    if (c != 8'hFF) begin
      c = c + 8'd1;
    end
    return c;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // debounce of every channel, one independent counter pair each
  always_comb begin
    status_d    = status_q;
    any_alarm_d = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (in_data_i.alarm_pins[i]) begin
        lo_cnt_d[i] = '0;
        hi_cnt_d[i] = run_adv(hi_cnt_q[i], ceil_q);
        if (hi_cnt_d[i] > athr_q) begin
          status_d[i] = 1'b0;
        end
      end else begin
        hi_cnt_d[i] = '0;
        lo_cnt_d[i] = run_adv(lo_cnt_q[i], ceil_q);
        if (lo_cnt_d[i] > athr_q) begin
          status_d[i] = 1'b1;
        end
        any_alarm_d = 1'b1;
      end
    end
  end

  // mute key with press lock
  always_comb begin
    key_cnt_d  = key_cnt_q;
    key_lock_d = key_lock_q;
    mute_d     = mute_q;
    if (in_data_i.key_pin) begin
      key_lock_d = 1'b0;
      key_cnt_d  = '0;
    end else if (!key_lock_q) begin
      key_cnt_d = (key_cnt_q != 8'hFF) ? key_cnt_q + 8'd1 : key_cnt_q;
      if (key_cnt_d > kthr_q) begin
        key_cnt_d  = '0;
        key_lock_d = 1'b1;
        mute_d     = !mute_q;
      end
    end
  end

  // lamps per gas, over and under latched until the gas is normal
  always_comb begin
    latch_d  = latch_q;
    normal_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (in_data_i.alarm_pins[2*g] && in_data_i.alarm_pins[2*g+1]) begin
        normal_d[g]     = 1'b1;
        latch_d[2*g]    = 1'b0;
        latch_d[2*g+1]  = 1'b0;
      end else begin
        if (!in_data_i.alarm_pins[2*g]) begin
          latch_d[2*g] = 1'b1;
        end
        if (!in_data_i.alarm_pins[2*g+1]) begin
          latch_d[2*g+1] = 1'b1;
        end
      end
    end
  end

  // drain timing and queue status
  assign dc_inc     = dc_q + 16'd1;
  assign drain_fire = dc_inc > period_q;
  assign pop        = cmd_i.tick && drain_fire && (fill_q != '0);
  assign full       = (fill_q == FW'(QUEUE_DEPTH));
  assign ch         = cmd_i.ch[CHW-1:0];
  assign chg        = status_q[ch] != reported_q[ch];
  assign code_w     = status_q[ch] ? aidq_pkg::code_t'(cmd_i.ch)
                                   : aidq_pkg::code_t'(cmd_i.ch) + aidq_pkg::CLEAR_OFFSET;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      athr_q   <= aidq_pkg::ALARM_THRESHOLD_RST;
      ceil_q   <= aidq_pkg::COUNT_CEILING_RST;
      kthr_q   <= aidq_pkg::KEY_THRESHOLD_RST;
      period_q <= aidq_pkg::DRAIN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (aidq_pkg::cfg_idx_e'(cfg_index_i))
        aidq_pkg::CFG_ALARM_THRESHOLD: athr_q   <= cfg_wdata_i[7:0];
        aidq_pkg::CFG_COUNT_CEILING:   ceil_q   <= cfg_wdata_i[7:0];
        aidq_pkg::CFG_KEY_THRESHOLD:   kthr_q   <= cfg_wdata_i[7:0];
        aidq_pkg::CFG_DRAIN_PERIOD:    period_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // tick update and one channel of the queue scan per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hi_cnt_q[i] <= '0;
        lo_cnt_q[i] <= '0;
      end
      status_q    <= '0;
      reported_q  <= '0;
      key_cnt_q   <= '0;
      key_lock_q  <= 1'b0;
      mute_q      <= 1'b0;
      latch_q     <= '0;
      normal_q    <= '0;
      any_alarm_q <= 1'b0;
      dc_q        <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      msg_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (cmd_i.tick) begin
      hi_cnt_q    <= hi_cnt_d;
      lo_cnt_q    <= lo_cnt_d;
      status_q    <= status_d;
      key_cnt_q   <= key_cnt_d;
      key_lock_q  <= key_lock_d;
      mute_q      <= mute_d;
      latch_q     <= latch_d;
      normal_q    <= normal_d;
      any_alarm_q <= any_alarm_d;
      dc_q        <= drain_fire ? '0 : dc_inc;
      msg_valid_q <= pop;
      ovf_q       <= 1'b0;
      if (pop) begin
        head_q <= ptr_inc(head_q);
        fill_q <= fill_q - FW'(1);
      end
    end else if (cmd_i.enq && chg) begin
      reported_q[ch] <= status_q[ch];
      if (!full) begin
        tail_q <= ptr_inc(tail_q);
        fill_q <= fill_q + FW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // queue memory, registered read on a drain
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && chg && !full) begin
      mem[tail_q] <= code_w;
    end
    if (pop) begin
      rd_q <= mem[head_q];
    end
  end

  // result assembly
  always_comb begin
    out_d                  = '0;
    out_d.normal_lamps     = '0;
    out_d.over_lamps       = '0;
    out_d.under_lamps      = '0;
    out_d.qualified_status = '0;
    out_d.normal_lamps[NG-1:0]             = normal_q;
    for (int g = 0; g < NG; g++) begin
      out_d.over_lamps[g]  = latch_q[2*g];
      out_d.under_lamps[g] = latch_q[2*g+1];
    end
    out_d.qualified_status[CHANNELS-1:0]   = status_q;
    out_d.beep_on        = any_alarm_q && !mute_q;
    out_d.muted          = mute_q;
    out_d.message_valid  = msg_valid_q;
    out_d.message_code   = msg_valid_q ? rd_q : '0;
    out_d.queue_overflow = ovf_q;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  // fill never goes past the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH))
    else $error("aidq_dp: queue fill beyond depth");

  // a change seen on a full queue is flagged as dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enq && chg && full) |=> (ovf_q && full))
    else $error("aidq_dp: dropped event not flagged");

  // a drain removes exactly one entry and marks the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (msg_valid_q && fill_q == $past(fill_q) - FW'(1)))
    else $error("aidq_dp: drain did not pop one entry");
`endif

endmodule
`default_nettype wire
